// ===== rtl/tcw_pkg.sv =====
// shared types and constants for the text console writer
package tcw_pkg;

	localparam int KIND_W  = 1;
	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int CELL_W  = 16;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int POS_W   = 11;
	localparam int ATTR_W  = 8;

	localparam logic [KIND_W-1:0] KIND_PUT  = 1'b0;
	localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FILL
	} state_t;

endpackage

// ===== rtl/text_console_writer.sv =====
// text console writer top level: screen memory, cursor and sequencer
// put: result in the cycle after the transfer; newline likewise
// put that scrolls: result after the fill state has blanked the new last row
// read: the memory read is registered, then the read state loads the cell into the result register
// after reset busy stays high while the screen is cleared
// results cannot be stalled; done is high for exactly one cycle per item
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tcw_pkg::KIND_W-1:0]    kind,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::INDEX_W-1:0]   read_index,
	input  logic                          text_attribute_we,
	input  logic [tcw_pkg::ATTR_W-1:0]    text_attribute,
	output logic                          done,
	output logic [tcw_pkg::CELL_W-1:0]    cell_value,
	output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
	output logic [tcw_pkg::COL_W-1:0]     cursor_column,
	output logic [tcw_pkg::POS_W-1:0]     cursor_position,
	output logic                          scrolled
);

	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(CELLS + 1);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int CW    = $clog2(COLUMNS + 1);
	localparam int XW    = ((PW > INDEX_W) ? PW : INDEX_W) + 1;

	state_t state_q, state_d;

	logic [ATTR_W-1:0] attr_q;
	logic [RW-1:0]     row_q, row_n;
	logic [CW-1:0]     col_q, col_n;
	logic [PW-1:0]     pos_q, pos_n;
	logic [AW-1:0]     base_q;
	logic [AW-1:0]     fbase_q;
	logic [CW-1:0]     fill_q;
	logic [AW-1:0]     clr_q;
	logic              done_q;
	logic              scrolled_q;
	logic [CELL_W-1:0] cell_q;

	logic              accept;
	logic              is_read;
	logic              is_nl;
	logic              idx_ok;
	logic              wrap;
	logic [XW-1:0]     lin;
	logic [XW-1:0]     phys_sum;
	logic [AW-1:0]     phys;
	logic [AW:0]       base_adv;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [CELL_W-1:0] mem_rdata;

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(phys),
		.rdata(mem_rdata)
	);

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign is_read = (kind == KIND_READ);
	assign is_nl   = (char_code == NEWLINE_CODE);
	assign idx_ok  = (XW'(read_index) < XW'(CELLS));

	// logical position to physical address through the rotating row base
	assign lin      = is_read ? XW'(read_index) : XW'(pos_q);
	assign phys_sum = lin + XW'(base_q);
	assign phys     = (phys_sum >= XW'(CELLS)) ? AW'(phys_sum - XW'(CELLS)) : AW'(phys_sum);
	assign base_adv = (AW + 1)'(base_q) + (AW + 1)'(COLUMNS);

	// cursor update for a put
	always_comb begin
		logic [RW-1:0] row_t;
		logic [PW-1:0] pos_t;
		col_n = '0;
		row_t = row_q;
		pos_t = pos_q;
		if (is_nl) begin
			row_t = row_q + RW'(1);
			pos_t = pos_q + PW'(CW'(COLUMNS) - col_q);
		end else begin
			pos_t = pos_q + PW'(1);
			if (col_q + CW'(1) == CW'(COLUMNS)) begin
				row_t = row_q + RW'(1);
			end else begin
				col_n = col_q + CW'(1);
			end
		end
		wrap = (row_t == RW'(ROWS));
		if (wrap) begin
			row_n = RW'(ROWS - 1);
			pos_n = pos_t - PW'(COLUMNS);
		end else begin
			row_n = row_t;
			pos_n = pos_t;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = phys;
		mem_wdata = {attr_q, char_code};
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {RESET_ATTR, SPACE_CODE};
				if (clr_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (is_read) begin
						if (idx_ok) begin
							state_d = ST_READ;
						end
					end else begin
						mem_we = !is_nl;
						if (wrap) begin
							state_d = ST_FILL;
						end
					end
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fbase_q + AW'(fill_q);
				mem_wdata = {attr_q, SPACE_CODE};
				if (fill_q == CW'(COLUMNS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q     <= RESET_ATTR;
			row_q      <= '0;
			col_q      <= '0;
			pos_q      <= '0;
			base_q     <= '0;
			fbase_q    <= '0;
			fill_q     <= '0;
			clr_q      <= '0;
			done_q     <= 1'b0;
			scrolled_q <= 1'b0;
		end else begin
			if (text_attribute_we) begin
				attr_q <= text_attribute;
			end
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						if (is_read) begin
							scrolled_q <= 1'b0;
							done_q     <= !idx_ok;
						end else begin
							row_q      <= row_n;
							col_q      <= col_n;
							pos_q      <= pos_n;
							scrolled_q <= wrap;
							done_q     <= !wrap;
							fill_q     <= '0;
							if (wrap) begin
								fbase_q <= base_q;
								base_q  <= (base_adv == (AW + 1)'(CELLS)) ? '0 : AW'(base_adv);
							end
						end
					end
				end
				ST_READ: begin
					done_q <= 1'b1;
				end
				ST_FILL: begin
					fill_q <= fill_q + CW'(1);
					if (fill_q == CW'(COLUMNS - 1)) begin
						done_q <= 1'b1;
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// result cell value, zero for puts and out of range reads
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			cell_q <= mem_rdata;
		end else if (accept) begin
			cell_q <= '0;
		end
	end

	assign done            = done_q;
	assign cell_value      = cell_q;
	assign scrolled        = scrolled_q;
	assign cursor_row      = ROW_W'(row_q);
	assign cursor_column   = COL_W'(col_q);
	assign cursor_position = POS_W'(pos_q);

endmodule

// ===== rtl/tcw_ram.sv =====
// generic single write port ram with registered read
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the text console writer: directed table, then random phases
`timescale 1ns / 1ps

module tb_top;
	import tcw_pkg::*;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = COLUMNS * ROWS;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 290;
	localparam int SCROLL_WAIT = 2 * COLUMNS;

	typedef struct packed {
		logic [CELL_W-1:0]  data;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [POS_W-1:0]   pos;
		logic               scr;
	} cursor_report_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CHAR_W-1:0]  ch;
		logic [INDEX_W-1:0] idx;
		logic               typed;
		cursor_report_t     rep;
	} screen_op_t;

	localparam screen_op_t DIRECTED [0:24] = '{
		'{KIND_READ, 8'h00, 11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0, 11'd0,  1'b0}},
		'{KIND_READ, 8'hFF, 11'd1999, 1'b1, '{16'h0720, 5'd0, 7'd0, 11'd0,  1'b0}},
		'{KIND_READ, 8'h00, 11'd2000, 1'b1, '{16'h0000, 5'd0, 7'd0, 11'd0,  1'b0}},
		'{KIND_READ, 8'h00, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0, 11'd0,  1'b0}},
		'{KIND_PUT,  8'h00, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd1, 11'd1,  1'b0}},
		'{KIND_PUT,  8'hFF, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd2, 11'd2,  1'b0}},
		'{KIND_READ, 8'h00, 11'd0,    1'b1, '{16'h0700, 5'd0, 7'd2, 11'd2,  1'b0}},
		'{KIND_READ, 8'h00, 11'd1,    1'b1, '{16'h07FF, 5'd0, 7'd2, 11'd2,  1'b0}},
		'{KIND_PUT,  NEWLINE_CODE, 11'd0, 1'b1, '{16'h0000, 5'd1, 7'd0, 11'd80, 1'b0}},
		'{KIND_READ, 8'h00, 11'd2,    1'b1, '{16'h0720, 5'd1, 7'd0, 11'd80, 1'b0}},
		'{KIND_PUT,  8'h41, 11'd2047, 1'b1, '{16'h0000, 5'd1, 7'd1, 11'd81, 1'b0}},
		'{KIND_READ, 8'hFF, 11'd80,   1'b1, '{16'h0741, 5'd1, 7'd1, 11'd81, 1'b0}},
		'{KIND_PUT,  8'h0B, 11'd5,    1'b0, '0},
		'{KIND_PUT,  8'h09, 11'd6,    1'b0, '0},
		'{KIND_PUT,  8'h7F, 11'd7,    1'b0, '0},
		'{KIND_PUT,  8'h80, 11'd8,    1'b0, '0},
		'{KIND_PUT,  NEWLINE_CODE, 11'd1024, 1'b0, '0},
		'{KIND_PUT,  NEWLINE_CODE, 11'd0,    1'b0, '0},
		'{KIND_READ, 8'h0A, 11'd81,   1'b0, '0},
		'{KIND_READ, 8'h55, 11'd1023, 1'b0, '0},
		'{KIND_READ, 8'hAA, 11'd1024, 1'b0, '0},
		'{KIND_PUT,  SPACE_CODE, 11'd0, 1'b0, '0},
		'{KIND_READ, 8'h00, 11'd1998, 1'b0, '0},
		'{KIND_PUT,  8'h55, 11'd1024, 1'b0, '0},
		'{KIND_READ, 8'h00, 11'd3,    1'b0, '0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [KIND_W-1:0]   kind = KIND_PUT;
	logic [CHAR_W-1:0]   char_code = '0;
	logic [INDEX_W-1:0]  read_index = '0;
	logic                text_attribute_we = 1'b0;
	logic [ATTR_W-1:0]   text_attribute = RESET_ATTR;
	logic                done;
	logic [CELL_W-1:0]   cell_value;
	logic [ROW_W-1:0]    cursor_row;
	logic [COL_W-1:0]    cursor_column;
	logic [POS_W-1:0]    cursor_position;
	logic                scrolled;

	// model of the screen contents, cursor and attribute
	logic [CELL_W-1:0]   shadow_screen [0:CELLS-1];
	int                  shadow_row;
	int                  shadow_col;
	logic [ATTR_W-1:0]   shadow_attr;

	cursor_report_t      screen_reports [$];
	int                  mismatch_count = 0;
	int                  burst_left = 0;
	bit                  quiet_burst = 1'b0;
	int                  line_left = 0;

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.char_code(char_code),
		.read_index(read_index),
		.text_attribute_we(text_attribute_we),
		.text_attribute(text_attribute),
		.done(done),
		.cell_value(cell_value),
		.cursor_row(cursor_row),
		.cursor_column(cursor_column),
		.cursor_position(cursor_position),
		.scrolled(scrolled)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void clear_screen_model();
		for (int i = 0; i < CELLS; i++) begin
			shadow_screen[i] = {RESET_ATTR, SPACE_CODE};
		end
		shadow_row  = 0;
		shadow_col  = 0;
		shadow_attr = RESET_ATTR;
	endfunction

	function automatic cursor_report_t apply_console_item(input logic [KIND_W-1:0] k,
			input logic [CHAR_W-1:0] c, input logic [INDEX_W-1:0] i);
		cursor_report_t r;
		int             at;
		r = '0;
		if (k == KIND_READ) begin
			if (int'(i) < CELLS) begin
				r.data = shadow_screen[i];
			end
		end else begin
			if (c == NEWLINE_CODE) begin
				shadow_col = 0;
				shadow_row++;
			end else begin
				at = shadow_row * COLUMNS + shadow_col;
				if (at < CELLS) begin
					shadow_screen[at] = {shadow_attr, c};
				end
				shadow_col++;
				if (shadow_col >= COLUMNS) begin
					shadow_col = 0;
					shadow_row++;
				end
			end
			if (shadow_row >= ROWS) begin
				for (int j = 0; j + COLUMNS < CELLS; j++) begin
					shadow_screen[j] = shadow_screen[j + COLUMNS];
				end
				for (int j = CELLS - COLUMNS; j < CELLS; j++) begin
					shadow_screen[j] = {shadow_attr, SPACE_CODE};
				end
				shadow_row = ROWS - 1;
				r.scr = 1'b1;
			end
		end
		r.row = shadow_row[ROW_W-1:0];
		r.col = shadow_col[COL_W-1:0];
		r.pos = POS_W'(shadow_row * COLUMNS + shadow_col);
		return r;
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] c,
			input logic [INDEX_W-1:0] i, input int gap, input logic typed,
			input cursor_report_t typed_rep);
		cursor_report_t predicted;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start      <= 1'b1;
		kind       <= k;
		char_code  <= c;
		read_index <= i;
		do @(posedge clk); while (busy);
		predicted = apply_console_item(k, c, i);
		screen_reports.push_back(typed ? typed_rep : predicted);
	endtask

	task automatic drain_reports();
		@(negedge clk);
		start <= 1'b0;
		while (screen_reports.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		@(negedge clk);
		text_attribute_we <= 1'b1;
		text_attribute    <= value;
		@(negedge clk);
		text_attribute_we <= 1'b0;
		shadow_attr = value;
	endtask

	function automatic int next_gap();
		if (burst_left == 0) begin
			burst_left  = $urandom_range(5, 40);
			quiet_burst = ($urandom_range(0, 2) == 0);
		end
		burst_left--;
		return quiet_burst ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic run_text_phase(input int count, input int line_span);
		logic [KIND_W-1:0]  k;
		logic [CHAR_W-1:0]  c;
		logic [INDEX_W-1:0] i;
		int                 pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				k = KIND_READ;
				c = CHAR_W'($urandom);
				i = (pick < 3) ? INDEX_W'($urandom_range(CELLS, 2047))
				               : INDEX_W'($urandom_range(0, CELLS - 1));
			end else begin
				k = KIND_PUT;
				i = INDEX_W'($urandom);
				if (line_left == 0) begin
					c = NEWLINE_CODE;
					line_left = $urandom_range(0, line_span);
				end else begin
					c = CHAR_W'($urandom_range(0, 255));
					line_left--;
				end
			end
			send_item(k, c, i, next_gap(), 1'b0, '0);
		end
	endtask

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		cursor_report_t got;
		cursor_report_t want;
		if (arst_n && done) begin
			got = '{cell_value, cursor_row, cursor_column, cursor_position, scrolled};
			if (screen_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result: cell %h row %0d col %0d pos %0d scrolled %0b",
						got.data, got.row, got.col, got.pos, got.scr);
				end
			end else begin
				want = screen_reports.pop_front();
				if (got.data !== want.data || got.row !== want.row || got.col !== want.col ||
						got.pos !== want.pos || got.scr !== want.scr) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: cell %h/%h row %0d/%0d col %0d/%0d pos %0d/%0d scrolled %0b/%0b (exp/act)",
							want.data, got.data, want.row, got.row, want.col, got.col,
							want.pos, got.pos, want.scr, got.scr);
					end
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		clear_screen_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int n = 0; n < 25; n++) begin
			send_item(DIRECTED[n].kind, DIRECTED[n].ch, DIRECTED[n].idx,
				$urandom_range(0, 3), DIRECTED[n].typed, DIRECTED[n].rep);
		end

		drain_reports();
		write_attribute(8'hFF);
		run_text_phase(PHASE_ITEMS, 120);
		drain_reports();
		write_attribute(8'h00);
		run_text_phase(PHASE_ITEMS, 10);
		drain_reports();
		write_attribute(ATTR_W'($urandom));
		run_text_phase(PHASE_ITEMS, 200);
		drain_reports();
		write_attribute(8'h1E);
		run_text_phase(PHASE_ITEMS, 40);
		drain_reports();
		write_attribute(ATTR_W'($urandom));
		run_text_phase(PHASE_ITEMS, 90);

		@(negedge clk);
		start <= 1'b0;
		while (screen_reports.size() != 0) @(posedge clk);
		repeat (SCROLL_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
